[rtl/core/sptq_pkg.sv]
// shared types, widths and codes for the stable priority task queue
package sptq_pkg;

   // queue geometry and field widths
   localparam int DEPTH     = 16;
   localparam int PRIO_BITS = 8;
   localparam int TAG_BITS  = 16;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int KIND_BITS = 3;
   localparam int STAT_BITS = 2;

   // operation codes carried on the request tuser
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_POP    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 3'd4;

   // status codes carried on the response tuser
   localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY     = 2'd3;

   // one queue slot
   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // slot store access from the sequencer
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic [IDX_BITS-1:0] rd_addr;
   } store_req_type;

   // finished operation handed to the response register
   typedef struct packed {
      logic [STAT_BITS-1:0] status;
      logic                 found;
      logic [PRIO_BITS-1:0] head_prio;
      logic [TAG_BITS-1:0]  head_tag;
      logic [CNT_BITS-1:0]  fill;
   } result_type;

endpackage

[rtl/core/sptq_store.sv]
// slot store: one write port and one registered read port
module sptq_store (
   input  logic                   clock,
   input  sptq_pkg::store_req_type req,
   output sptq_pkg::entry_type     rd_data
);

   sptq_pkg::entry_type mem [sptq_pkg::DEPTH];
   sptq_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sptq_ctrl.sv]
// sequencer that walks the slots through one shared compare and move step
module sptq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sptq_pkg::KIND_BITS-1:0]    kind,
   input  logic [sptq_pkg::PRIO_BITS-1:0]    task_prio,
   input  logic [sptq_pkg::TAG_BITS-1:0]     task_tag,
   output logic                              idle,
   output logic                              done,
   input  logic                              done_take,
   output sptq_pkg::result_type              result,
   output sptq_pkg::store_req_type           store_req,
   input  sptq_pkg::entry_type               rd_data
);

   localparam int ST_BITS = 3;
   localparam logic [ST_BITS-1:0] S_IDLE    = 3'd0;
   localparam logic [ST_BITS-1:0] S_INS_RD  = 3'd1;
   localparam logic [ST_BITS-1:0] S_INS_EV  = 3'd2;
   localparam logic [ST_BITS-1:0] S_INS_PUT = 3'd3;
   localparam logic [ST_BITS-1:0] S_SCN_RD  = 3'd4;
   localparam logic [ST_BITS-1:0] S_SCN_EV  = 3'd5;
   localparam logic [ST_BITS-1:0] S_SHF_RD  = 3'd6;
   localparam logic [ST_BITS-1:0] S_SHF_EV  = 3'd7;

   localparam logic [sptq_pkg::CNT_BITS-1:0] ONE  = sptq_pkg::CNT_BITS'(1);
   localparam logic [sptq_pkg::CNT_BITS-1:0] TWO  = sptq_pkg::CNT_BITS'(2);
   localparam logic [sptq_pkg::CNT_BITS-1:0] FULL = sptq_pkg::CNT_BITS'(sptq_pkg::DEPTH);

   logic [ST_BITS-1:0]              state_ff, state_in;
   logic                            done_ff, done_in;
   logic [sptq_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [sptq_pkg::CNT_BITS-1:0]   idx_ff, idx_in;
   logic [sptq_pkg::KIND_BITS-1:0]  kind_ff, kind_in;
   logic [sptq_pkg::PRIO_BITS-1:0]  prio_ff, prio_in;
   logic [sptq_pkg::TAG_BITS-1:0]   tag_ff, tag_in;
   logic [sptq_pkg::STAT_BITS-1:0]  status_ff, status_in;
   logic                            found_ff, found_in;
   logic [sptq_pkg::PRIO_BITS-1:0]  hprio_ff, hprio_in;
   logic [sptq_pkg::TAG_BITS-1:0]   htag_ff, htag_in;

   logic [sptq_pkg::CNT_BITS-1:0]   idx_next;
   logic [sptq_pkg::CNT_BITS-1:0]   idx_prev;
   logic                            prio_ge;
   logic                            tag_eq;
   logic                            at_last;
   sptq_pkg::entry_type             new_entry;

   // shared compare unit and index arithmetic
   assign idx_next  = idx_ff + ONE;
   assign idx_prev  = idx_ff - ONE;
   assign prio_ge   = (rd_data.prio >= prio_ff);
   assign tag_eq    = (rd_data.tag == tag_ff);
   assign at_last   = (idx_next == count_ff);
   assign new_entry = '{prio: prio_ff, tag: tag_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      prio_ff   <= prio_in;
      tag_ff    <= tag_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      hprio_ff  <= hprio_in;
      htag_ff   <= htag_in;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      prio_in   = prio_ff;
      tag_in    = tag_ff;
      status_in = status_ff;
      found_in  = found_ff;
      hprio_in  = hprio_ff;
      htag_in   = htag_ff;

      store_req.wr_en   = 1'b0;
      store_req.wr_addr = idx_next[sptq_pkg::IDX_BITS-1:0];
      store_req.wr_data = new_entry;
      store_req.rd_addr = idx_ff[sptq_pkg::IDX_BITS-1:0];

      case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               if (done_take) begin
                  done_in = 1'b0;
               end
            end else if (start) begin
               kind_in   = kind;
               prio_in   = task_prio;
               tag_in    = task_tag;
               status_in = sptq_pkg::STAT_OK;
               found_in  = 1'b0;
               hprio_in  = '0;
               htag_in   = '0;
               idx_in    = '0;
               case (kind)
                  sptq_pkg::KIND_INSERT: begin
                     if (count_ff == FULL) begin
                        status_in = sptq_pkg::STAT_FULL;
                        done_in   = 1'b1;
                     end else if (count_ff == '0) begin
                        state_in = S_INS_PUT;
                     end else begin
                        idx_in   = count_ff - ONE;
                        state_in = S_INS_RD;
                     end
                  end
                  sptq_pkg::KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = sptq_pkg::STAT_NOT_FOUND;
                        done_in   = 1'b1;
                     end else begin
                        state_in = S_SCN_RD;
                     end
                  end
                  sptq_pkg::KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = sptq_pkg::STAT_EMPTY;
                        done_in   = 1'b1;
                     end else begin
                        state_in = S_SCN_RD;
                     end
                  end
                  sptq_pkg::KIND_LOOKUP: begin
                     if (count_ff == '0) begin
                        done_in = 1'b1;
                     end else begin
                        state_in = S_SCN_RD;
                     end
                  end
                  sptq_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     done_in  = 1'b1;
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end

         // insert walks from the tail towards the head, moving lower entries down
         S_INS_RD: begin
            state_in = S_INS_EV;
         end
         S_INS_EV: begin
            store_req.wr_en = 1'b1;
            if (prio_ge) begin
               count_in = count_ff + ONE;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               store_req.wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_INS_PUT;
               end else begin
                  idx_in   = idx_prev;
                  state_in = S_INS_RD;
               end
            end
         end
         S_INS_PUT: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = idx_ff[sptq_pkg::IDX_BITS-1:0];
            count_in          = count_ff + ONE;
            done_in           = 1'b1;
            state_in          = S_IDLE;
         end

         // search from the head; pop takes the head as its match
         S_SCN_RD: begin
            state_in = S_SCN_EV;
         end
         S_SCN_EV: begin
            if (kind_ff == sptq_pkg::KIND_POP || tag_eq) begin
               if (kind_ff == sptq_pkg::KIND_POP) begin
                  hprio_in = rd_data.prio;
                  htag_in  = rd_data.tag;
               end else begin
                  found_in = 1'b1;
               end
               if (kind_ff == sptq_pkg::KIND_LOOKUP) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else if (at_last) begin
                  count_in = count_ff - ONE;
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SHF_RD;
               end
            end else if (at_last) begin
               if (kind_ff == sptq_pkg::KIND_REMOVE) begin
                  status_in = sptq_pkg::STAT_NOT_FOUND;
               end
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_next;
               state_in = S_SCN_RD;
            end
         end

         // close the gap: slot idx takes slot idx plus one
         S_SHF_RD: begin
            store_req.rd_addr = idx_next[sptq_pkg::IDX_BITS-1:0];
            state_in          = S_SHF_EV;
         end
         S_SHF_EV: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = idx_ff[sptq_pkg::IDX_BITS-1:0];
            store_req.wr_data = rd_data;
            if (idx_ff + TWO == count_ff) begin
               count_in = count_ff - ONE;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_next;
               state_in = S_SHF_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle             = (state_ff == S_IDLE) && !done_ff;
   assign done             = done_ff;
   assign result.status    = status_ff;
   assign result.found     = found_ff;
   assign result.head_prio = hprio_ff;
   assign result.head_tag  = htag_ff;
   assign result.fill      = count_ff;

endmodule

[rtl/core/stable_priority_task_queue_core.sv]
// top level of the stable priority task queue: stream ports and response register
//
//  channel | dir | beat fields (tdata / tuser, lowest bit first)
//  req_    | in  | tdata: task_prio[7:0], task_tag[23:8]; tuser: kind[2:0]
//  rsp_    | out | tdata: head_prio[7:0], head_tag[23:8], fill[28:24]; tuser: status, found
//
// insert walks from the tail towards the head, moving lower entries down, with a last write
// when the new task lands at the head; remove, lookup and pop scan from the head; clear and
// refused operations touch no slot; the registered slot store read paces each walk.
// reset empties the queue at once; slot contents are left as they are.
// a response waiting in the output register lets the next request start;
// it only stalls the sequencer at its hand-over step.
module stable_priority_task_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // task_prio[7:0], task_tag[23:8]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // head_prio[7:0], head_tag[23:8], fill[28:24], zero
   output logic [2:0]  rsp_tuser    // status[1:0], found[2]
);

   sptq_pkg::store_req_type store_req;
   sptq_pkg::entry_type     rd_data;
   sptq_pkg::result_type    result;
   sptq_pkg::result_type    rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    idle;
   logic                    done;
   logic                    take;

   sptq_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (rd_data)
   );

   sptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid),
      .kind      (req_tuser),
      .task_prio (req_tdata[sptq_pkg::PRIO_BITS-1:0]),
      .task_tag  (req_tdata[sptq_pkg::PRIO_BITS +: sptq_pkg::TAG_BITS]),
      .idle      (idle),
      .done      (done),
      .done_take (take),
      .result    (result),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   assign req_tready = idle;

   // response register loads when empty or being drained
   assign take = done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // beat packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.fill, rsp_ff.head_tag, rsp_ff.head_prio};
   assign rsp_tuser  = {rsp_ff.found, rsp_ff.status};

endmodule

[dv/stable_priority_task_queue_core_tb.sv]
// self-checking testbench for the stable priority task queue core
module stable_priority_task_queue_core_tb;

   // kinds that carry no operation
   localparam logic [sptq_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [sptq_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 80;

   // mirror of the queue contents and the responses still owed by the block
   class task_queue_mirror;
      logic [sptq_pkg::PRIO_BITS-1:0] slot_prio [sptq_pkg::DEPTH];
      logic [sptq_pkg::TAG_BITS-1:0]  slot_tag [sptq_pkg::DEPTH];
      int                             held;
      sptq_pkg::result_type           awaited [$];
      int                             mismatches;

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      // first slot holding the tag, or held when there is none
      function int locate(logic [sptq_pkg::TAG_BITS-1:0] tag);
         for (int i = 0; i < held; i++) begin
            if (slot_tag[i] == tag) return i;
         end
         return held;
      endfunction

      // take out one slot and close the gap
      function void drop_slot(int pos);
         for (int i = pos; i + 1 < held; i++) begin
            slot_prio[i] = slot_prio[i + 1];
            slot_tag[i]  = slot_tag[i + 1];
         end
         held--;
      endfunction

      // apply one accepted request beat and queue the response it owes
      function void note_request(logic [sptq_pkg::KIND_BITS-1:0] kind,
                                 logic [sptq_pkg::PRIO_BITS-1:0] prio,
                                 logic [sptq_pkg::TAG_BITS-1:0] tag);
         sptq_pkg::result_type r;
         int                   pos;
         r = '0;
         r.status = sptq_pkg::STAT_OK;
         case (kind)
            sptq_pkg::KIND_INSERT: begin
               if (held >= sptq_pkg::DEPTH) begin
                  r.status = sptq_pkg::STAT_FULL;
               end else begin
                  // new task goes behind every entry of equal or higher priority
                  pos = 0;
                  while (pos < held && slot_prio[pos] >= prio) pos++;
                  for (int i = held; i > pos; i--) begin
                     slot_prio[i] = slot_prio[i - 1];
                     slot_tag[i]  = slot_tag[i - 1];
                  end
                  slot_prio[pos] = prio;
                  slot_tag[pos]  = tag;
                  held++;
               end
            end
            sptq_pkg::KIND_REMOVE: begin
               pos = locate(tag);
               if (pos < held) begin
                  r.found = 1'b1;
                  drop_slot(pos);
               end else begin
                  r.status = sptq_pkg::STAT_NOT_FOUND;
               end
            end
            sptq_pkg::KIND_POP: begin
               if (held == 0) begin
                  r.status = sptq_pkg::STAT_EMPTY;
               end else begin
                  r.head_prio = slot_prio[0];
                  r.head_tag  = slot_tag[0];
                  drop_slot(0);
               end
            end
            sptq_pkg::KIND_LOOKUP: begin
               r.found = (locate(tag) < held);
            end
            sptq_pkg::KIND_CLEAR: begin
               held = 0;
            end
            default: begin
            end
         endcase
         r.fill = held[sptq_pkg::CNT_BITS-1:0];
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted response beat with the oldest owed response
      function void check_response(logic [31:0] data, logic [2:0] user);
         sptq_pkg::result_type want;
         sptq_pkg::result_type got;
         got.head_prio = data[7:0];
         got.head_tag  = data[23:8];
         got.fill      = data[28:24];
         got.status    = user[1:0];
         got.found     = user[2];
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %p", $time, got);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("head_prio", 32'(want.head_prio), 32'(got.head_prio));
            compare_field("head_tag", 32'(want.head_tag), 32'(got.head_tag));
            compare_field("fill", 32'(want.fill), 32'(got.fill));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   task_queue_mirror book = new();
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               cycle_count = 0;

   stable_priority_task_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL stable_priority_task_queue_core");
         $finish;
      end
   end

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_response(rsp_tdata, rsp_tuser);
   end

   // drive one request beat; entered and left at a falling edge
   task automatic send_op(input logic [sptq_pkg::KIND_BITS-1:0] kind,
                          input logic [sptq_pkg::PRIO_BITS-1:0] prio,
                          input logic [sptq_pkg::TAG_BITS-1:0] tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tag, prio};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      book.note_request(kind, prio, tag);
      @(negedge clock);
   endtask

   // random operations in modes that fill, drain or mix the queue
   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      int                             mode;
      int                             roll;
      logic [sptq_pkg::KIND_BITS-1:0] kind;
      logic [sptq_pkg::PRIO_BITS-1:0] prio;
      logic [sptq_pkg::TAG_BITS-1:0]  tag;
      logic [sptq_pkg::TAG_BITS-1:0]  tag_pool [6];
      int                             lim_ins, lim_look, lim_rem, lim_pop, lim_clr;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      mode = 0;
      for (int n = 0; n < count; n++) begin
         // new mode and tag pool every 48 beats
         if (n % 48 == 0) begin
            mode = $urandom_range(2);
            foreach (tag_pool[i]) begin
               tag_pool[i] = sptq_pkg::TAG_BITS'($urandom_range(16'hffff));
            end
         end
         case (mode)
            0: begin lim_ins = 65; lim_look = 75; lim_rem = 85; lim_pop = 96; lim_clr = 97; end
            1: begin lim_ins = 15; lim_look = 30; lim_rem = 55; lim_pop = 90; lim_clr = 93; end
            default: begin
               lim_ins = 35; lim_look = 55; lim_rem = 75; lim_pop = 92; lim_clr = 96;
            end
         endcase
         roll = $urandom_range(99);
         if (roll < lim_ins) kind = sptq_pkg::KIND_INSERT;
         else if (roll < lim_look) kind = sptq_pkg::KIND_LOOKUP;
         else if (roll < lim_rem) kind = sptq_pkg::KIND_REMOVE;
         else if (roll < lim_pop) kind = sptq_pkg::KIND_POP;
         else if (roll < lim_clr) kind = sptq_pkg::KIND_CLEAR;
         else kind = sptq_pkg::KIND_BITS'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
         // mostly low priorities so that ties are common
         if ($urandom_range(3) == 0) prio = sptq_pkg::PRIO_BITS'($urandom_range(255));
         else prio = sptq_pkg::PRIO_BITS'($urandom_range(3));
         if ($urandom_range(3) == 0) tag = sptq_pkg::TAG_BITS'($urandom_range(16'hffff));
         else tag = tag_pool[$urandom_range(5)];
         send_op(kind, prio, tag);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue and spare kinds
      send_op(sptq_pkg::KIND_POP, 8'h00, 16'h0000);
      send_op(sptq_pkg::KIND_REMOVE, 8'h11, 16'h1234);
      send_op(KIND_SPARE_LO, 8'hff, 16'hffff);
      send_op(KIND_SPARE_HI, 8'h00, 16'h0000);
      // fill up with extremes, ties and a duplicate tag
      send_op(sptq_pkg::KIND_INSERT, 8'h00, 16'h0000);
      send_op(sptq_pkg::KIND_INSERT, 8'hff, 16'hffff);
      send_op(sptq_pkg::KIND_INSERT, 8'hff, 16'h00a5);
      send_op(sptq_pkg::KIND_INSERT, 8'h80, 16'h5a5a);
      send_op(sptq_pkg::KIND_INSERT, 8'h80, 16'h5a5a);
      send_op(sptq_pkg::KIND_INSERT, 8'h00, 16'h0001);
      for (int i = 0; i < 10; i++) begin
         send_op(sptq_pkg::KIND_INSERT, 8'(i * 23), 16'hc3c3 ^ 16'(i));
      end
      // refused insert on a full queue
      send_op(sptq_pkg::KIND_INSERT, 8'hc8, 16'h7777);
      send_op(sptq_pkg::KIND_LOOKUP, 8'h00, 16'h5a5a);
      send_op(sptq_pkg::KIND_LOOKUP, 8'h00, 16'hbeef);
      send_op(sptq_pkg::KIND_REMOVE, 8'h00, 16'h5a5a);
      send_op(sptq_pkg::KIND_REMOVE, 8'h00, 16'hbeef);
      send_op(sptq_pkg::KIND_POP, 8'h00, 16'h0000);
      send_op(sptq_pkg::KIND_CLEAR, 8'h00, 16'h0000);
      send_op(sptq_pkg::KIND_POP, 8'h00, 16'h0000);

      // random phases with different idling on each side
      run_random(410, 0, 0);
      run_random(410, 79, 0);
      run_random(410, 0, 79);
      run_random(410, 12, 12);
      req_tvalid <= 1'b0;

      // drain the owed responses, then watch for stray beats
      recv_stall_pct = 0;
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.awaited.size() == 0) begin
         $display("PASS stable_priority_task_queue_core");
      end else begin
         $display("FAIL stable_priority_task_queue_core");
      end
      $finish;
   end

endmodule
